>>> src/msc_pkg.sv
// Shared types, codes and constants of the MSI snoop line controller.
package msc_pkg;

    // Default sizes
    localparam int LINES_DEF   = 1024;
    localparam int ID_BITS_DEF = 4;

    // Fixed field widths
    localparam int CMD_W   = 3;
    localparam int SLOT_W  = 10;
    localparam int ADDR_W  = 32;
    localparam int RID_W   = 4;
    localparam int CNT_W   = 32;
    localparam int ERR_W   = 2;
    localparam int ST_W    = 3;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 80;

    typedef logic [ST_W-1:0]  line_st_t;
    typedef logic [CMD_W-1:0] cmd_t;
    typedef logic [ERR_W-1:0] err_t;

    // Line states
    localparam line_st_t ST_I  = 3'd0;
    localparam line_st_t ST_S  = 3'd1;
    localparam line_st_t ST_M  = 3'd2;
    localparam line_st_t ST_IM = 3'd3;
    localparam line_st_t ST_IS = 3'd4;

    // Commands
    localparam cmd_t CMD_LOAD  = 3'd0;
    localparam cmd_t CMD_STORE = 3'd1;
    localparam cmd_t CMD_GETS  = 3'd2;
    localparam cmd_t CMD_GETM  = 3'd3;
    localparam cmd_t CMD_DATA  = 3'd4;

    // Error codes
    localparam err_t ERR_NONE        = 2'd0;
    localparam err_t ERR_OUTSTANDING = 2'd1;
    localparam err_t ERR_OWNED_DATA  = 2'd2;

    // Actions decided for one transfer
    typedef struct packed {
        logic             issue_gets;
        logic             issue_getm;
        logic             data_to_proc;
        logic             data_on_bus;
        logic             shared_assert;
        logic [RID_W-1:0] reply_dest;
        logic             miss;
        err_t             error_code;
        line_st_t         new_state;
    } line_act_t;

endpackage

>>> src/msi_snoop_line_controller_top.sv
// Top level of the MSI snoop line controller: line state table, pipeline, result register.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+----------------------------------------------
//  s_      | in  | s_tvalid / s_tready | s_tuser = cmd, s_tdata = slot, addr, requester
//  m_      | out | m_tvalid / m_tready | m_tdata = actions, miss count, error, state
//
//  One transfer per cycle sustained while m_ is not stalled; a result passes the registered
//  read of the line state table, then the result register.
//  After reset the table is cleared to I one entry per cycle, with s_tready low until the
//  pass ends. A stall on m_ holds the result; one more input is still taken into the
//  input stage, further inputs wait. Back-to-back items on one slot use a bypass of the
//  last written state.
module msi_snoop_line_controller_top #(
    parameter int LINES   = msc_pkg::LINES_DEF,
    parameter int ID_BITS = msc_pkg::ID_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [9:0] line_slot, [41:10] addr, [45:42] requester_id
    input  logic [msc_pkg::S_TDATA_W-1:0]   s_tdata,
    // [2:0] cmd
    input  logic [msc_pkg::CMD_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] issue_gets, [1] issue_getm, [2] data_to_proc, [3] data_on_bus,
    // [4] shared_assert, [8:5] reply_dest, [40:9] out_addr, [41] miss,
    // [73:42] miss_total, [75:74] error_code, [78:76] new_line_state
    output logic [msc_pkg::M_TDATA_W-1:0]   m_tdata
);

    localparam int IDX_W = (LINES > 1) ? $clog2(LINES) : 1;

    // Input field unpacking
    logic [msc_pkg::SLOT_W-1:0] s_slot;
    logic [IDX_W-1:0]           s_idx;
    assign s_slot = s_tdata[msc_pkg::SLOT_W-1:0];
    assign s_idx  = IDX_W'(s_slot);

    // Control
    logic clr_busy_reg;
    logic [IDX_W-1:0] clr_idx_reg;
    logic p1_valid_reg;
    logic out_valid_reg;
    logic s_fire;
    logic adv;

    // Input stage payload
    msc_pkg::cmd_t              p1_cmd_reg;
    logic [msc_pkg::SLOT_W-1:0] p1_slot_reg;
    logic [msc_pkg::ADDR_W-1:0] p1_addr_reg;
    logic [msc_pkg::RID_W-1:0]  p1_rid_reg;
    msc_pkg::line_st_t          p1_rd_reg;

    // Bypass of the last write
    logic                       byp_valid_reg;
    logic [IDX_W-1:0]           byp_idx_reg;
    msc_pkg::line_st_t          byp_st_reg;

    logic [msc_pkg::CNT_W-1:0]  miss_cnt_reg;
    logic [msc_pkg::CNT_W-1:0]  miss_cnt_next;
    logic [msc_pkg::M_TDATA_W-1:0] out_data_reg;

    // Line state table
    msc_pkg::line_st_t line_mem [LINES];

    assign adv      = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !clr_busy_reg && (!p1_valid_reg || adv);
    assign s_fire   = s_tvalid && s_tready;

    // Stage 1 decode
    logic [IDX_W-1:0]          p1_idx;
    logic                      p1_in_range;
    msc_pkg::line_st_t         p1_cur;
    logic [msc_pkg::RID_W-1:0] rid_mask;
    msc_pkg::line_act_t        act;

    assign p1_idx      = IDX_W'(p1_slot_reg);
    assign p1_in_range = (32'(p1_slot_reg) < 32'(LINES));
    assign p1_cur      = (byp_valid_reg && byp_idx_reg == p1_idx) ? byp_st_reg : p1_rd_reg;

    // Keep only the low ID_BITS bits of the requester id
    always_comb begin
        for (int i = 0; i < msc_pkg::RID_W; i++) begin
            rid_mask[i] = (i < ID_BITS) ? p1_rid_reg[i] : 1'b0;
        end
    end

    msc_line_fsm u_fsm (
        .cmd       (p1_cmd_reg),
        .cur_state (p1_cur),
        .in_range  (p1_in_range),
        .rid       (rid_mask),
        .act       (act)
    );

    // Saturating miss count
    assign miss_cnt_next = (act.miss && (miss_cnt_reg != '1)) ?
                           miss_cnt_reg + 1'b1 : miss_cnt_reg;

    // Table write port (clearing pass or writeback) and registered read port
    logic              wr_en;
    logic [IDX_W-1:0]  wr_idx;
    msc_pkg::line_st_t wr_st;

    assign wr_en  = clr_busy_reg || (adv && p1_in_range);
    assign wr_idx = clr_busy_reg ? clr_idx_reg : p1_idx;
    assign wr_st  = clr_busy_reg ? msc_pkg::ST_I : act.new_state;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_idx] <= wr_st;
        end
        if (s_fire) begin
            p1_rd_reg <= line_mem[s_idx];
        end
    end

    // Clearing pass after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end else if (clr_busy_reg) begin
            if (clr_idx_reg == IDX_W'(LINES - 1)) begin
                clr_busy_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    // Input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            p1_valid_reg <= 1'b1;
        end else if (adv) begin
            p1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            p1_cmd_reg  <= s_tuser;
            p1_slot_reg <= s_slot;
            p1_addr_reg <= s_tdata[msc_pkg::SLOT_W +: msc_pkg::ADDR_W];
            p1_rid_reg  <= s_tdata[msc_pkg::SLOT_W + msc_pkg::ADDR_W +: msc_pkg::RID_W];
        end
    end

    // Bypass and miss counter follow each writeback
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_valid_reg <= 1'b0;
            miss_cnt_reg  <= '0;
        end else if (adv) begin
            miss_cnt_reg <= miss_cnt_next;
            if (p1_in_range) begin
                byp_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && p1_in_range) begin
            byp_idx_reg <= p1_idx;
            byp_st_reg  <= act.new_state;
        end
    end

    // Result register
    logic                       any_act;
    logic [msc_pkg::ADDR_W-1:0] out_addr;
    assign any_act  = act.issue_gets | act.issue_getm | act.data_to_proc | act.data_on_bus;
    assign out_addr = any_act ? p1_addr_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_data_reg <= {1'b0, act.new_state, act.error_code, miss_cnt_next,
                             act.miss, out_addr, act.reply_dest, act.shared_assert,
                             act.data_on_bus, act.data_to_proc, act.issue_getm,
                             act.issue_gets};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> src/msc_line_fsm.sv
// Per-line MSI transition logic: actions and next state for one command.
module msc_line_fsm (
    input  msc_pkg::cmd_t                 cmd,
    input  msc_pkg::line_st_t             cur_state,
    input  logic                          in_range,
    input  logic [msc_pkg::RID_W-1:0]     rid,
    output msc_pkg::line_act_t            act
);

    always_comb begin
        act = '0;
        act.new_state = cur_state;
        if (!in_range) begin
            // Slot beyond the table: nothing happens, state reads as I
            act.new_state = msc_pkg::ST_I;
        end else begin
            case (cur_state)
                msc_pkg::ST_I: begin
                    if (cmd == msc_pkg::CMD_LOAD) begin
                        act.issue_gets = 1'b1;
                        act.miss       = 1'b1;
                        act.new_state  = msc_pkg::ST_IS;
                    end else if (cmd == msc_pkg::CMD_STORE) begin
                        act.issue_getm = 1'b1;
                        act.miss       = 1'b1;
                        act.new_state  = msc_pkg::ST_IM;
                    end
                end
                msc_pkg::ST_S: begin
                    if (cmd == msc_pkg::CMD_LOAD) begin
                        act.data_to_proc = 1'b1;
                    end else if (cmd == msc_pkg::CMD_STORE) begin
                        act.issue_getm = 1'b1;
                        act.miss       = 1'b1;
                        act.new_state  = msc_pkg::ST_IM;
                    end else if (cmd == msc_pkg::CMD_GETM) begin
                        act.new_state = msc_pkg::ST_I;
                    end else if (cmd == msc_pkg::CMD_DATA) begin
                        act.error_code = msc_pkg::ERR_OWNED_DATA;
                    end
                end
                msc_pkg::ST_M: begin
                    if (cmd inside {msc_pkg::CMD_LOAD, msc_pkg::CMD_STORE}) begin
                        act.data_to_proc = 1'b1;
                    end else if (cmd inside {msc_pkg::CMD_GETS, msc_pkg::CMD_GETM}) begin
                        // Owner supplies the line and downgrades
                        act.shared_assert = 1'b1;
                        act.data_on_bus   = 1'b1;
                        act.reply_dest    = rid;
                        act.new_state     = (cmd == msc_pkg::CMD_GETS) ?
                                            msc_pkg::ST_S : msc_pkg::ST_I;
                    end else if (cmd == msc_pkg::CMD_DATA) begin
                        act.error_code = msc_pkg::ERR_OWNED_DATA;
                    end
                end
                msc_pkg::ST_IM, msc_pkg::ST_IS: begin
                    if (cmd inside {msc_pkg::CMD_LOAD, msc_pkg::CMD_STORE}) begin
                        act.error_code = msc_pkg::ERR_OUTSTANDING;
                    end else if (cmd == msc_pkg::CMD_DATA) begin
                        // Fill completes the pending request
                        act.data_to_proc = 1'b1;
                        act.new_state    = (cur_state == msc_pkg::ST_IM) ?
                                           msc_pkg::ST_M : msc_pkg::ST_S;
                    end
                end
                default: begin
                    act.new_state = msc_pkg::ST_I;
                end
            endcase
        end
    end

endmodule
